/* hw/rtl/bitmap_block_allocator_assert.svh */
// Assertion macros for the bitmap block allocator.
`ifndef BITMAP_BLOCK_ALLOCATOR_ASSERT_SVH
`define BITMAP_BLOCK_ALLOCATOR_ASSERT_SVH
`ifndef SYNTHESIS
`define BBA_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bba assertion failed");
`define BBA_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bba assertion failed");
`else
`define BBA_ASSERT_SAME(lbl, ante, cons)
`define BBA_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

/* hw/rtl/bba_pkg.sv */
// Shared constants, types and functions of the bitmap block allocator.
package bba_pkg;

    localparam int NUM_BLOCKS  = 4096;
    localparam int WORD_BITS   = 32;
    localparam int BIT_IDX_W   = $clog2(WORD_BITS);
    localparam int MAP_WORDS   = (NUM_BLOCKS + WORD_BITS - 1) / WORD_BITS;
    localparam int WORD_IDX_W  = $clog2(MAP_WORDS);
    localparam int BLOCK_W     = 12;
    localparam int COUNT_W     = 13;
    localparam int PADDR_W     = 3;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    localparam logic REG_FIRST_DATA_BLOCK = 1'b0;
    localparam logic REG_BLOCK_COUNT      = 1'b1;

    typedef logic [WORD_BITS-1:0]  word_t;
    typedef logic [WORD_IDX_W-1:0] word_idx_t;
    typedef logic [BIT_IDX_W-1:0]  bit_idx_t;

    typedef struct packed {
        logic      we;
        word_idx_t addr;
        word_t     wdata;
    } ram_req_t;

    function automatic bit_idx_t lowest_set(input word_t w);
        bit_idx_t pos;
        pos = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--)
        begin
            if (w[i])
            begin
                pos = bit_idx_t'(i);
            end
        end
        return pos;
    endfunction

endpackage

/* hw/rtl/bba_map_ram.sv */
// Occupancy bitmap word memory with per-row valid bits; unwritten rows read as zero.
module bba_map_ram
(
    input  logic              clk,
    input  logic              rst_n,
    input  bba_pkg::ram_req_t req,
    output bba_pkg::word_t    rdata
);
    import bba_pkg::*;

    word_t                mem [MAP_WORDS];
    logic [MAP_WORDS-1:0] row_valid_reg;
    word_t                rd_data_reg;
    logic                 rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.addr] <= req.wdata;
        end
        rd_data_reg <= mem[req.addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg <= '0;
            rd_valid_reg  <= 1'b0;
        end
        else
        begin
            if (req.we)
            begin
                row_valid_reg[req.addr] <= 1'b1;
            end
            rd_valid_reg <= row_valid_reg[req.addr];
        end
    end

    assign rdata = rd_valid_reg ? rd_data_reg : '0;

endmodule

/* hw/rtl/bitmap_block_allocator.sv */
// Top level of the first-fit bitmap block allocator.
// Usage:
//   Input channel (in_valid/in_stall) carries command and block_number.
//   command 0 allocates the lowest free block in [first_data_block,
//   min(block_count, 4096)); command 1 frees block_number.
//   Output channel (out_valid/out_stall) returns granted_block and full_res,
//   one transaction per input transaction, in order.
//   Registers over APB: 0x0 first_data_block, 0x4 block_count; pready is
//   always high; write only while idle.
// Sequence: free reads the bitmap word, clears its bit, writes it back.
//   Allocate scans one bitmap word at a time (one word read, one 32-bit
//   free-bit search), then writes the hit word back; an empty range
//   reports full without a scan. Each ends in finish, which loads the
//   output register; the next transaction is accepted back in idle.
// One transaction is in work at a time; in_stall is high while busy.
//   A finished result may wait in the output register while the next
//   transaction is accepted; a stalled receiver holds the block in its
//   final state until the output register frees.
// Reset clears the bitmap (per-word valid bits, no sweep), the registers
//   to first_data_block 0 and block_count 4096, and the output channel.
`include "bitmap_block_allocator_assert.svh"
module bitmap_block_allocator
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          command,
    input  logic [bba_pkg::BLOCK_W-1:0]   block_number,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [bba_pkg::BLOCK_W-1:0]   granted_block,
    output logic                          full_res,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [bba_pkg::PADDR_W-1:0]   paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    import bba_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_READ   = 3'd1;
    localparam logic [2:0] S_CHECK  = 3'd2;
    localparam logic [2:0] S_WRITE  = 3'd3;
    localparam logic [2:0] S_FINISH = 3'd4;

    localparam word_t ALL_ONES = '1;
    localparam logic [COUNT_W-1:0] LIMIT_MAX = COUNT_W'(NUM_BLOCKS);

    logic [2:0]           state_reg, state_next;
    logic [BLOCK_W-1:0]   first_reg;
    logic [COUNT_W-1:0]   count_reg;
    logic                 cmd_reg, cmd_next;
    logic [BLOCK_W-1:0]   blk_reg, blk_next;
    word_idx_t            widx_reg, widx_next;
    word_t                wdata_reg, wdata_next;
    logic [BLOCK_W-1:0]   res_blk_reg, res_blk_next;
    logic                 res_full_reg, res_full_next;
    logic                 out_valid_reg;
    logic [BLOCK_W-1:0]   out_blk_reg;
    logic                 out_full_reg;

    ram_req_t             ram_req;
    word_t                rdata;
    logic [COUNT_W-1:0]   limit;
    logic [COUNT_W-1:0]   lim_m1;
    logic                 range_empty;
    word_idx_t            first_word;
    word_idx_t            last_word;
    word_t                lo_mask;
    word_t                hi_mask;
    word_t                free_bits;
    logic                 hit;
    bit_idx_t             pos;
    logic                 in_accept;
    logic                 out_free;
    logic                 cfg_write;

    bba_map_ram u_map_ram
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (ram_req),
        .rdata (rdata)
    );

    assign limit       = (count_reg > LIMIT_MAX) ? LIMIT_MAX : count_reg;
    assign lim_m1      = limit - COUNT_W'(1);
    assign range_empty = {1'b0, first_reg} >= limit;
    assign first_word  = first_reg[BLOCK_W-1 -: WORD_IDX_W];
    assign last_word   = lim_m1[BLOCK_W-1 -: WORD_IDX_W];

    assign lo_mask   = (widx_reg == first_word) ? (ALL_ONES << first_reg[BIT_IDX_W-1:0])
                                                : ALL_ONES;
    assign hi_mask   = (widx_reg == last_word)
                       ? (ALL_ONES >> (bit_idx_t'(WORD_BITS - 1) - lim_m1[BIT_IDX_W-1:0]))
                       : ALL_ONES;
    assign free_bits = ~rdata & lo_mask & hi_mask;
    assign hit       = |free_bits;
    assign pos       = lowest_set(free_bits);

    assign in_stall  = (state_reg != S_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;

    assign ram_req.we    = (state_reg == S_WRITE);
    assign ram_req.addr  = widx_reg;
    assign ram_req.wdata = wdata_reg;

    always_comb
    begin
        state_next    = state_reg;
        cmd_next      = cmd_reg;
        blk_next      = blk_reg;
        widx_next     = widx_reg;
        wdata_next    = wdata_reg;
        res_blk_next  = res_blk_reg;
        res_full_next = res_full_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    cmd_next      = command;
                    blk_next      = block_number;
                    res_blk_next  = '0;
                    res_full_next = 1'b0;
                    if (command == CMD_FREE)
                    begin
                        widx_next  = block_number[BLOCK_W-1 -: WORD_IDX_W];
                        state_next = S_READ;
                    end
                    else if (range_empty)
                    begin
                        res_full_next = 1'b1;
                        state_next    = S_FINISH;
                    end
                    else
                    begin
                        widx_next  = first_word;
                        state_next = S_READ;
                    end
                end
            end
            S_READ:
            begin
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (cmd_reg == CMD_FREE)
                begin
                    wdata_next = rdata & ~(word_t'(1) << blk_reg[BIT_IDX_W-1:0]);
                    state_next = S_WRITE;
                end
                else if (hit)
                begin
                    wdata_next   = rdata | (word_t'(1) << pos);
                    res_blk_next = {widx_reg, pos};
                    state_next   = S_WRITE;
                end
                else if (widx_reg == last_word)
                begin
                    res_full_next = 1'b1;
                    state_next    = S_FINISH;
                end
                else
                begin
                    widx_next  = widx_reg + word_idx_t'(1);
                    state_next = S_READ;
                end
            end
            S_WRITE:
            begin
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_FINISH && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        blk_reg      <= blk_next;
        widx_reg     <= widx_next;
        wdata_reg    <= wdata_next;
        res_blk_reg  <= res_blk_next;
        res_full_reg <= res_full_next;
        if (state_reg == S_FINISH && out_free)
        begin
            out_blk_reg  <= res_blk_reg;
            out_full_reg <= res_full_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign granted_block = out_blk_reg;
    assign full_res      = out_full_reg;

    // APB register file
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_reg <= '0;
            count_reg <= LIMIT_MAX;
        end
        else if (cfg_write)
        begin
            unique case (paddr[2])
                REG_FIRST_DATA_BLOCK: first_reg <= pwdata[BLOCK_W-1:0];
                REG_BLOCK_COUNT:      count_reg <= pwdata[COUNT_W-1:0];
                default:              ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_FIRST_DATA_BLOCK: prdata = {{(32-BLOCK_W){1'b0}}, first_reg};
            REG_BLOCK_COUNT:      prdata = {{(32-COUNT_W){1'b0}}, count_reg};
            default:              prdata = '0;
        endcase
    end

    `BBA_ASSERT_SAME(a_full_grants_zero, out_valid_reg && out_full_reg, out_blk_reg == '0)
    `BBA_ASSERT_NEXT(a_accept_busy, in_accept, state_reg != S_IDLE)
    `BBA_ASSERT_NEXT(a_hit_writes, state_reg == S_CHECK && cmd_reg == CMD_ALLOC && hit, state_reg == S_WRITE && wdata_reg[pos] == 1'b1)
    `BBA_ASSERT_SAME(a_scan_in_range, state_reg == S_READ && cmd_reg == CMD_ALLOC, widx_reg <= last_word && widx_reg >= first_word)

endmodule

/* verif/tb.sv */
// Testbench for the bitmap block allocator: directed and random traffic checked per field.
`timescale 1ns / 100ps

module tb;
    import bba_pkg::*;

    localparam int LIMIT_CYCLES = 1500000;
    localparam int TAIL_CYCLES  = 300;
    localparam int RAND_PHASES  = 10;
    localparam int PHASE_OPS    = 95;

    typedef struct packed {
        logic [BLOCK_W-1:0] granted;
        logic               full;
    } grant_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic               command = CMD_ALLOC;
    logic [BLOCK_W-1:0] block_number = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic [BLOCK_W-1:0] granted_block;
    logic               full_res;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;

    // allocator mirror
    bit                 occupancy [NUM_BLOCKS];
    logic [BLOCK_W-1:0] first_blk = '0;
    logic [COUNT_W-1:0] blk_count = COUNT_W'(NUM_BLOCKS);

    grant_t pending_grants [$];
    int     held_blocks [$];

    int  errors = 0;
    int  burst_left = 0;
    bit  valid_high = 1'b0;
    int  stall_mode = 0;
    int  stall_left = 0;
    int  n_alloc = 0;
    int  n_granted = 0;
    int  n_full = 0;
    int  n_free = 0;
    int  n_settings = 0;

    bitmap_block_allocator dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .command       (command),
        .block_number  (block_number),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .granted_block (granted_block),
        .full_res      (full_res),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial
    begin
        forever
        begin
            #1 clk = ~clk;
        end
    end

    initial
    begin
        repeat (LIMIT_CYCLES) @(posedge clk);
        $display("timeout after %0d cycles, %0d transactions outstanding",
                 LIMIT_CYCLES, pending_grants.size());
        $display("** bitmap_block_allocator: FAILED **");
        $finish;
    end

    function automatic grant_t predict_op(input logic cmd, input logic [BLOCK_W-1:0] blk);
        grant_t res;
        int     limit;
        res = '0;
        if (cmd == CMD_FREE)
        begin
            occupancy[blk] = 1'b0;
            return res;
        end
        limit = (int'(blk_count) > NUM_BLOCKS) ? NUM_BLOCKS : int'(blk_count);
        for (int n = int'(first_blk); n < limit; n++)
        begin
            if (!occupancy[n])
            begin
                occupancy[n] = 1'b1;
                res.granted = BLOCK_W'(n);
                return res;
            end
        end
        res.full = 1'b1;
        return res;
    endfunction

    // receiver back-pressure: free running, light, heavy and solid stretches
    always @(posedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode = $urandom_range(0, 3);
            stall_left = (stall_mode == 3) ? $urandom_range(5, 30) : $urandom_range(10, 120);
        end
        stall_left--;
        case (stall_mode)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(0, 99) < 25);
            2: out_stall <= ($urandom_range(0, 99) < 75);
            default: out_stall <= 1'b1;
        endcase
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_grants.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected transaction granted_block=%0d full_res=%0b",
                         $time, granted_block, full_res);
            end
            else
            begin
                grant_t exp_res;
                exp_res = pending_grants.pop_front();
                if (granted_block !== exp_res.granted)
                begin
                    errors++;
                    $display("%0t: granted_block expected %0d actual %0d",
                             $time, exp_res.granted, granted_block);
                end
                if (full_res !== exp_res.full)
                begin
                    errors++;
                    $display("%0t: full_res expected %0b actual %0b",
                             $time, exp_res.full, full_res);
                end
            end
        end
    end

    task automatic write_reg(input logic reg_idx, input int unsigned value);
        logic [31:0] mask;
        logic [31:0] data;
        mask = (reg_idx == REG_FIRST_DATA_BLOCK) ? 32'h0000_0FFF : 32'h0000_1FFF;
        // junk above the register width must be dropped
        data = ($urandom() & ~mask) | (value & mask);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_idx, 2'b00};
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (reg_idx == REG_FIRST_DATA_BLOCK)
            first_blk = data[BLOCK_W-1:0];
        else
            blk_count = data[COUNT_W-1:0];
        n_settings++;
        @(posedge clk);
        if (prdata !== (data & mask))
        begin
            errors++;
            $display("%0t: register %0d readback expected %0h actual %0h",
                     $time, reg_idx, data & mask, prdata);
        end
    endtask

    task automatic send_op(input logic cmd, input logic [BLOCK_W-1:0] blk);
        grant_t res;
        if (burst_left == 0)
        begin
            if (valid_high)
            begin
                in_valid <= 1'b0;
                valid_high = 1'b0;
                repeat ($urandom_range(1, 20)) @(posedge clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        in_valid     <= 1'b1;
        command      <= cmd;
        block_number <= blk;
        valid_high = 1'b1;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        res = predict_op(cmd, blk);
        pending_grants.push_back(res);
        if (cmd == CMD_FREE)
            n_free++;
        else
        begin
            n_alloc++;
            if (res.full)
                n_full++;
            else
            begin
                n_granted++;
                held_blocks.push_back(int'(res.granted));
            end
        end
    endtask

    task automatic wait_idle();
        if (valid_high)
        begin
            in_valid <= 1'b0;
            valid_high = 1'b0;
            @(posedge clk);
        end
        burst_left = 0;
        while (pending_grants.size() != 0) @(posedge clk);
    endtask

    task automatic test_reset_defaults();
        send_op(CMD_ALLOC, 12'hFFF);
        send_op(CMD_ALLOC, 12'h000);
        send_op(CMD_FREE, 12'h000);
        send_op(CMD_FREE, 12'hFFF);
        send_op(CMD_ALLOC, 12'h555);
        send_op(CMD_FREE, 12'hAAA);
    endtask

    task automatic test_range_edges();
        wait_idle();
        write_reg(REG_BLOCK_COUNT, 32'h1FFF);
        write_reg(REG_FIRST_DATA_BLOCK, 32'hFFF);
        send_op(CMD_ALLOC, 12'h000);
        send_op(CMD_ALLOC, 12'hFFF);
        send_op(CMD_FREE, 12'hFFF);
        send_op(CMD_ALLOC, 12'h123);
        wait_idle();
        write_reg(REG_BLOCK_COUNT, 0);
        send_op(CMD_ALLOC, 12'h000);
        wait_idle();
        write_reg(REG_BLOCK_COUNT, 4095);
        send_op(CMD_ALLOC, 12'hFFF);
        wait_idle();
        write_reg(REG_FIRST_DATA_BLOCK, 10);
        write_reg(REG_BLOCK_COUNT, 12);
        send_op(CMD_ALLOC, 12'h000);
        send_op(CMD_ALLOC, 12'h000);
        send_op(CMD_ALLOC, 12'h000);
        send_op(CMD_FREE, 12'd11);
        send_op(CMD_ALLOC, 12'hFFF);
        send_op(CMD_FREE, 12'd10);
        send_op(CMD_FREE, 12'd11);
    endtask

    task automatic test_random_traffic();
        int kind;
        int fdb;
        int sel;
        int idx;
        for (int phase = 0; phase < RAND_PHASES; phase++)
        begin
            wait_idle();
            if (phase < 4)
                kind = phase;
            else
                kind = ($urandom_range(0, 9) < 6) ? 3 : $urandom_range(0, 2);
            case (kind)
                0:
                begin
                    write_reg(REG_FIRST_DATA_BLOCK, 0);
                    write_reg(REG_BLOCK_COUNT, NUM_BLOCKS);
                end
                1:
                begin
                    write_reg(REG_FIRST_DATA_BLOCK, $urandom_range(4000, 4095));
                    write_reg(REG_BLOCK_COUNT, $urandom_range(4096, 8191));
                end
                2:
                begin
                    fdb = $urandom_range(1, 4095);
                    write_reg(REG_FIRST_DATA_BLOCK, fdb);
                    write_reg(REG_BLOCK_COUNT, $urandom_range(0, fdb));
                end
                default:
                begin
                    fdb = $urandom_range(0, 4000);
                    write_reg(REG_FIRST_DATA_BLOCK, fdb);
                    write_reg(REG_BLOCK_COUNT, fdb + $urandom_range(1, 90));
                end
            endcase
            for (int k = 0; k < PHASE_OPS; k++)
            begin
                sel = $urandom_range(0, 99);
                if (sel < 50 || held_blocks.size() == 0)
                    send_op(CMD_ALLOC, BLOCK_W'($urandom()));
                else if (sel < 88)
                begin
                    idx = $urandom_range(0, held_blocks.size() - 1);
                    send_op(CMD_FREE, BLOCK_W'(held_blocks[idx]));
                    held_blocks.delete(idx);
                end
                else
                    send_op(CMD_FREE, BLOCK_W'($urandom()));
            end
        end
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_defaults();
        test_range_edges();
        test_random_traffic();
        wait_idle();
        repeat (TAIL_CYCLES) @(posedge clk);
        $display("Run covered %0d allocations (%0d granted, %0d full) and %0d frees",
                 n_alloc, n_granted, n_full, n_free);
        $display("across %0d register writes, with random gaps and output back-pressure",
                 n_settings);
        if (errors == 0)
            $display("** bitmap_block_allocator: PASSED **");
        else
            $display("** bitmap_block_allocator: FAILED **");
        $finish;
    end

endmodule
